@@ design/binary_gcd_unit_macros.svh @@
// Assertion macros for the binary GCD unit.
// Included by the sequencer and the top level; needs nothing else.
`ifndef BINARY_GCD_UNIT_MACROS_SVH
`define BINARY_GCD_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BGCD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bgcd assertion failed");
`define BGCD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bgcd assertion failed");
`else
`define BGCD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define BGCD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/bgcd_pkg.sv @@
// Shared types, field widths and the microcode program of the binary GCD unit.
// No dependencies.
package bgcd_pkg;

   localparam int OPND_W = 16;   // width of each operand field
   localparam int DIV_W  = 16;   // width of the result field

   typedef logic [1:0] upc_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_REDUCE,
      OP_RESTORE,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      COND_NO_START,
      COND_B_NONZERO,
      COND_TWOS_NONZERO,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } uword_type;

   typedef struct packed {
      logic b_nonzero;
      logic twos_nonzero;
   } dp_status_type;

   typedef struct packed {
      logic          start;
      logic          out_busy;
      dp_status_type dp;
   } status_type;

   localparam upc_type STEP_LOAD    = 2'd0;
   localparam upc_type STEP_REDUCE  = 2'd1;
   localparam upc_type STEP_RESTORE = 2'd2;
   localparam upc_type STEP_EMIT    = 2'd3;

   // Jump is taken when the condition holds, otherwise the counter steps on.
   // The step after the emit wraps back to the load.
   function automatic uword_type ucode(upc_type pc);
      uword_type uw;
      case (pc)
         STEP_LOAD:    uw = '{OP_LOAD,    COND_NO_START,     STEP_LOAD};
         STEP_REDUCE:  uw = '{OP_REDUCE,  COND_B_NONZERO,    STEP_REDUCE};
         STEP_RESTORE: uw = '{OP_RESTORE, COND_TWOS_NONZERO, STEP_RESTORE};
         STEP_EMIT:    uw = '{OP_EMIT,    COND_OUT_BUSY,     STEP_EMIT};
         default:      uw = '{OP_LOAD,    COND_NO_START,     STEP_LOAD};
      endcase
      return uw;
   endfunction

endpackage

@@ design/bgcd_seq.sv @@
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on bgcd_pkg and binary_gcd_unit_macros.svh.
`include "binary_gcd_unit_macros.svh"

module bgcd_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  bgcd_pkg::status_type  status,
   output bgcd_pkg::uword_type   uword
);
   import bgcd_pkg::*;

   upc_type pc_ff, pc_in;
   logic    taken;

   assign uword = ucode(pc_ff);

   always_comb begin
      case (uword.cond)
         COND_NO_START:     taken = !status.start;
         COND_B_NONZERO:    taken = status.dp.b_nonzero;
         COND_TWOS_NONZERO: taken = status.dp.twos_nonzero;
         COND_OUT_BUSY:     taken = status.out_busy;
         default:           taken = 1'b0;
      endcase
      pc_in = taken ? uword.target : upc_type'(pc_ff + 2'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

   `BGCD_ASSERT_NEXT(a_reduce_exit, clock, reset,
      (uword.op == OP_REDUCE) && !status.dp.b_nonzero, uword.op == OP_RESTORE)
   `BGCD_ASSERT_NEXT(a_emit_wrap, clock, reset,
      (uword.op == OP_EMIT) && !status.out_busy, uword.op == OP_LOAD)
   `BGCD_ASSERT_NEXT(a_start_leaves, clock, reset,
      (uword.op == OP_LOAD) && status.start, uword.op == OP_REDUCE)

endmodule

@@ design/bgcd_dp.sv @@
// Datapath: operand registers, shared-twos counter, reduce and restore steps.
// Depends on bgcd_pkg.
module bgcd_dp #(
   parameter int WIDTH = 16
) (
   input  logic                            clock,
   input  bgcd_pkg::op_type                op,
   input  logic [bgcd_pkg::OPND_W-1:0]     operand_a,
   input  logic [bgcd_pkg::OPND_W-1:0]     operand_b,
   output logic [bgcd_pkg::DIV_W-1:0]      divisor,
   output bgcd_pkg::dp_status_type         dp_status
);
   import bgcd_pkg::*;

   localparam int TW = $clog2(WIDTH);

   logic [WIDTH-1:0]        a_ff, a_in, b_ff, b_in;
   logic [TW-1:0]           twos_ff, twos_in;
   logic [OPND_W+WIDTH-1:0] a_ext, b_ext;
   logic [DIV_W+WIDTH-1:0]  g_ext;
   logic [WIDTH-1:0]        hi, lo;

   // operands narrowed or widened to the working width
   assign a_ext = {{WIDTH{1'b0}}, operand_a};
   assign b_ext = {{WIDTH{1'b0}}, operand_b};
   assign g_ext = {{DIV_W{1'b0}}, a_ff};
   assign divisor = g_ext[DIV_W-1:0];

   assign dp_status.b_nonzero    = (b_ff != '0);
   assign dp_status.twos_nonzero = (twos_ff != '0);

   assign hi = (a_ff < b_ff) ? b_ff : a_ff;
   assign lo = (a_ff < b_ff) ? a_ff : b_ff;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      twos_in = twos_ff;
      case (op)
         OP_LOAD: begin
            a_in    = a_ext[WIDTH-1:0];
            b_in    = b_ext[WIDTH-1:0];
            twos_in = '0;
         end
         OP_REDUCE: begin
            if (b_ff != '0) begin
               case ({hi[0], lo[0]})
                  2'b11: begin
                     a_in = hi - lo;
                     b_in = lo;
                  end
                  2'b00: begin
                     a_in    = hi >> 1;
                     b_in    = lo >> 1;
                     twos_in = twos_ff + TW'(1);
                  end
                  2'b01: begin
                     a_in = hi >> 1;
                     b_in = lo;
                  end
                  default: begin
                     a_in = hi;
                     b_in = lo >> 1;
                  end
               endcase
            end
         end
         OP_RESTORE: begin
            // put back one shared factor of two per step
            if (twos_ff != '0) begin
               a_in    = a_ff << 1;
               twos_in = twos_ff - TW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      twos_ff <= twos_in;
   end

endmodule

@@ design/binary_gcd_unit.sv @@
// Top level of the binary GCD unit: stream ports, result register, sequencer, datapath.
// Depends on bgcd_pkg, bgcd_seq, bgcd_dp and binary_gcd_unit_macros.svh.
//
//   channel   direction  word contents
//   req_      in         operand_a, operand_b
//   rsp_      out        divisor
//
// A word passes from acceptance to the result register through the load step, the reduce
// loop, the restore loop that puts back the shared factors of two, and the emit step; the
// microcode loop over the one subtract/shift unit sets this. One word is in work at a time;
// the next is taken only once the last has left the emit step and the counter is back at load.
// Reset clears the step counter and the result valid flag.
// A stalled rsp_ side holds the engine at its emit step until the register frees.
`include "binary_gcd_unit_macros.svh"

module binary_gcd_unit #(
   parameter int WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [2*bgcd_pkg::OPND_W-1:0]       req_tdata,  // operand_a, operand_b
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bgcd_pkg::DIV_W-1:0]          rsp_tdata   // divisor
);
   import bgcd_pkg::*;

   uword_type          uword;
   status_type         status;
   dp_status_type      dp_status;
   logic [DIV_W-1:0]   result;
   logic [DIV_W-1:0]   rsp_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               emit;

   assign req_tready = (uword.op == OP_LOAD);

   assign status.start    = req_tvalid;
   assign status.out_busy = rsp_valid_ff && !rsp_tready;
   assign status.dp       = dp_status;

   assign emit         = (uword.op == OP_EMIT) && !status.out_busy;
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   bgcd_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uword  (uword)
   );

   bgcd_dp #(
      .WIDTH (WIDTH)
   ) u_dp (
      .clock     (clock),
      .op        (uword.op),
      .operand_a (req_tdata[OPND_W-1:0]),
      .operand_b (req_tdata[2*OPND_W-1:OPND_W]),
      .divisor   (result),
      .dp_status (dp_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `BGCD_ASSERT_NEXT(a_emit_lands, clock, reset,
      emit, rsp_tvalid && (rsp_tdata == $past(result)))
   `BGCD_ASSERT_IMPLY(a_no_overwrite, clock, reset,
      emit, !rsp_valid_ff || rsp_tready)
   `BGCD_ASSERT_IMPLY(a_emit_done, clock, reset,
      emit, !dp_status.b_nonzero && !dp_status.twos_nonzero)

endmodule
